[rtl/qrs_pkg.sv]
// Package for the quadratic root solver: widths, pipeline lengths, root kinds.
// No dependencies; used by qrs_div and quadratic_root_solver_unit.
package qrs_pkg;

  localparam int COEF_W   = 32;
  localparam int FRAC_W   = 16;
  localparam int TOL_W    = 31;
  localparam int PROD_W   = 2 * COEF_W;
  localparam int D_W      = PROD_W + 2;
  localparam int ROOT_W   = D_W / 2;
  localparam int NUM_W    = ROOT_W + 2;
  localparam int DEN_W    = COEF_W + 1;
  localparam int DIV_LAT  = COEF_W + 3;
  localparam int PIPE_LEN = 4 + (ROOT_W + 1) + 1 + DIV_LAT + 1;

  typedef enum logic [2:0] {
    K_NONE,
    K_INF,
    K_ZERO,
    K_LIN,
    K_DBL,
    K_TWO
  } kind_t;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_INF  = 2'd3;

  typedef struct packed {
    kind_t              kind;
    logic [COEF_W-1:0]  a;
    logic [COEF_W-1:0]  b;
    logic [COEF_W-1:0]  c;
  } side_t;

  typedef struct packed {
    logic [1:0] count;
    logic       use1;
    logic       use2;
  } res_side_t;

endpackage

[rtl/quadratic_root_solver_unit.sv]
// Quadratic root solver top level: tolerance register, products, square root, dividers.
// Depends on qrs_pkg and qrs_div.
//
// Takes one coefficient set per cycle while coef_stall is low and returns one
// result per set, in order. The pipeline runs through the 33-stage
// bit-per-stage square root followed by the 35-stage rounding dividers; the
// two roots are divided in parallel. root_stall freezes the whole pipeline and
// is reflected on coef_stall. zero_tolerance is written through cfg_valid /
// cfg_ready (always ready) and must only change while the pipeline is empty.
module quadratic_root_solver_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [qrs_pkg::TOL_W-1:0]           cfg_data,
  input  logic                                coef_valid,
  output logic                                coef_stall,
  input  logic signed [qrs_pkg::COEF_W-1:0]   coef_quadratic,
  input  logic signed [qrs_pkg::COEF_W-1:0]   coef_linear,
  input  logic signed [qrs_pkg::COEF_W-1:0]   coef_constant,
  output logic                                root_valid,
  input  logic                                root_stall,
  output logic [1:0]                          root_count,
  output logic signed [qrs_pkg::COEF_W-1:0]   first_root,
  output logic signed [qrs_pkg::COEF_W-1:0]   second_root,
  output logic                                saturated
);

  localparam int CW = qrs_pkg::COEF_W;
  localparam int RW = qrs_pkg::ROOT_W;
  localparam int DWD = qrs_pkg::D_W;
  localparam int PL = qrs_pkg::PIPE_LEN;
  localparam int DL = qrs_pkg::DIV_LAT;

  logic [qrs_pkg::TOL_W-1:0] tol;
  logic [qrs_pkg::TOL_W-1:0] tol_eff;
  logic                      en;
  logic [PL-1:0]             v;

  assign cfg_ready  = 1'b1;
  assign en         = !(root_valid && root_stall);
  assign coef_stall = !en;
  assign root_valid = v[PL-1];
  assign tol_eff    = (tol == '0) ? qrs_pkg::TOL_W'(1) : tol;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= qrs_pkg::TOL_W'(1);
      v   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        tol <= cfg_data;
      end
      if (en) begin
        v <= {v[PL-2:0], coef_valid};
      end
    end
  end

  // stage 1: capture
  logic [CW-1:0] a1, b1, c1;
  // stage 2: magnitudes and zero tests
  logic [CW-1:0] a2, b2r, c2, am2, bm2, cm2;
  logic          az2, bz2, cz2, cnz2;
  // stage 3: products
  logic [CW-1:0]                 a3, b3, c3;
  logic                          az3, bz3, cz3, cnz3;
  logic [qrs_pkg::PROD_W-1:0]    bb3, ac3;
  // stage 4: discriminant
  logic [CW-1:0]  a4, b4, c4;
  logic           az4, bz4, cz4, dneg4;
  logic [DWD-1:0] d4;

  logic [CW-1:0] am_c, bm_c, cm_c;
  logic          sdiff;
  logic [DWD-1:0] bb_w, ac4_w;

  always_comb begin
    am_c  = a1[CW-1] ? CW'(-a1) : a1;
    bm_c  = b1[CW-1] ? CW'(-b1) : b1;
    cm_c  = c1[CW-1] ? CW'(-c1) : c1;
    sdiff = (a3[CW-1] != c3[CW-1]) && cnz3;
    bb_w  = DWD'(bb3);
    ac4_w = {ac3, 2'b00};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1 <= coef_quadratic;
      b1 <= coef_linear;
      c1 <= coef_constant;

      a2   <= a1;
      b2r  <= b1;
      c2   <= c1;
      am2  <= am_c;
      bm2  <= bm_c;
      cm2  <= cm_c;
      az2  <= am_c < CW'(tol_eff);
      bz2  <= bm_c < CW'(tol_eff);
      cz2  <= cm_c < CW'(tol_eff);
      cnz2 <= cm_c != '0;

      a3   <= a2;
      b3   <= b2r;
      c3   <= c2;
      az3  <= az2;
      bz3  <= bz2;
      cz3  <= cz2;
      cnz3 <= cnz2;
      bb3  <= bm2 * bm2;
      ac3  <= am2 * cm2;

      a4    <= a3;
      b4    <= b3;
      c4    <= c3;
      az4   <= az3;
      bz4   <= bz3;
      cz4   <= cz3;
      d4    <= sdiff ? bb_w + ac4_w : bb_w - ac4_w;
      dneg4 <= !sdiff && (bb_w < ac4_w);
    end
  end

  // stage 5 onwards: classification and square root, one root bit per stage
  qrs_pkg::side_t  sd      [0:RW];
  logic [DWD-1:0]  sq_rem  [0:RW];
  logic [RW-1:0]   sq_root [0:RW];
  logic [DWD-1:0]  sq_rem_next  [1:RW];
  logic [RW-1:0]   sq_root_next [1:RW];
  qrs_pkg::kind_t  kind5;

  always_comb begin
    if (az4) begin
      if (bz4 && cz4) begin
        kind5 = qrs_pkg::K_INF;
      end else if (bz4) begin
        kind5 = qrs_pkg::K_NONE;
      end else if (cz4) begin
        kind5 = qrs_pkg::K_ZERO;
      end else begin
        kind5 = qrs_pkg::K_LIN;
      end
    end else if (dneg4) begin
      kind5 = qrs_pkg::K_NONE;
    end else if (d4 < (DWD'(tol_eff) << qrs_pkg::FRAC_W)) begin
      kind5 = qrs_pkg::K_DBL;
    end else begin
      kind5 = qrs_pkg::K_TWO;
    end
  end

  always_comb begin
    for (int k = 1; k <= RW; k++) begin
      logic [DWD-1:0] trial;
      trial = (DWD'(sq_root[k-1]) << (RW - k + 1)) | (DWD'(1) << (2 * (RW - k)));
      if (sq_rem[k-1] >= trial) begin
        sq_rem_next[k]  = sq_rem[k-1] - trial;
        sq_root_next[k] = sq_root[k-1] | (RW'(1) << (RW - k));
      end else begin
        sq_rem_next[k]  = sq_rem[k-1];
        sq_root_next[k] = sq_root[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0].kind <= kind5;
      sd[0].a    <= a4;
      sd[0].b    <= b4;
      sd[0].c    <= c4;
      sq_rem[0]  <= d4;
      sq_root[0] <= '0;
      for (int k = 1; k <= RW; k++) begin
        sd[k]      <= sd[k-1];
        sq_rem[k]  <= sq_rem_next[k];
        sq_root[k] <= sq_root_next[k];
      end
    end
  end

  // numerator and denominator forming
  localparam int SW = qrs_pkg::NUM_W + 1;

  logic [qrs_pkg::NUM_W-1:0] n1_mag, n2_mag;
  logic [qrs_pkg::DEN_W-1:0] dn_mag;
  logic                      neg1, neg2;
  qrs_pkg::res_side_t        rs [0:DL];

  qrs_pkg::side_t            sdn;
  logic signed [SW-1:0]      nb, nc, sv, num1, num2;
  logic [qrs_pkg::DEN_W-1:0] am_n, bm_n;
  logic                      den_neg;
  qrs_pkg::res_side_t        rs_next;

  always_comb begin
    sdn  = sd[RW];
    nb   = -SW'(signed'(sdn.b));
    nc   = -SW'(signed'(sdn.c));
    sv   = SW'(sq_root[RW]);
    am_n = sdn.a[CW-1] ? {1'b0, CW'(-sdn.a)} : {1'b0, sdn.a};
    bm_n = sdn.b[CW-1] ? {1'b0, CW'(-sdn.b)} : {1'b0, sdn.b};
    num1    = nb;
    num2    = nb;
    den_neg = sdn.a[CW-1];
    rs_next = '{count: qrs_pkg::CNT_NONE, use1: 1'b0, use2: 1'b0};
    unique case (sdn.kind)
      qrs_pkg::K_NONE: begin
        rs_next.count = qrs_pkg::CNT_NONE;
      end
      qrs_pkg::K_INF: begin
        rs_next.count = qrs_pkg::CNT_INF;
      end
      qrs_pkg::K_ZERO: begin
        rs_next.count = qrs_pkg::CNT_ONE;
      end
      qrs_pkg::K_LIN: begin
        rs_next.count = qrs_pkg::CNT_ONE;
        rs_next.use1  = 1'b1;
        num1          = nc;
        num2          = nc;
        den_neg       = sdn.b[CW-1];
      end
      qrs_pkg::K_DBL: begin
        rs_next.count = qrs_pkg::CNT_ONE;
        rs_next.use1  = 1'b1;
        rs_next.use2  = 1'b1;
      end
      qrs_pkg::K_TWO: begin
        rs_next.count = qrs_pkg::CNT_TWO;
        rs_next.use1  = 1'b1;
        rs_next.use2  = 1'b1;
        num1          = nb - sv;
        num2          = nb + sv;
      end
      default: begin
        rs_next.count = qrs_pkg::CNT_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1_mag <= num1[SW-1] ? qrs_pkg::NUM_W'(-num1) : qrs_pkg::NUM_W'(num1);
      n2_mag <= num2[SW-1] ? qrs_pkg::NUM_W'(-num2) : qrs_pkg::NUM_W'(num2);
      neg1   <= num1[SW-1] != den_neg;
      neg2   <= num2[SW-1] != den_neg;
      dn_mag <= (sdn.kind == qrs_pkg::K_LIN) ? bm_n : (am_n << 1);
      rs[0]  <= rs_next;
      for (int k = 1; k <= DL; k++) begin
        rs[k] <= rs[k-1];
      end
    end
  end

  logic [CW-1:0] q1, q2;
  logic          s1, s2;

  qrs_div u_div1 (
    .clk     (clk),
    .en      (en),
    .num_mag (n1_mag),
    .den_mag (dn_mag),
    .neg     (neg1),
    .quo     (q1),
    .sat     (s1)
  );

  qrs_div u_div2 (
    .clk     (clk),
    .en      (en),
    .num_mag (n2_mag),
    .den_mag (dn_mag),
    .neg     (neg2),
    .quo     (q2),
    .sat     (s2)
  );

  // output register
  qrs_pkg::res_side_t rf;

  always_comb begin
    rf = rs[DL];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root_count  <= rf.count;
      first_root  <= rf.use1 ? q1 : '0;
      second_root <= rf.use2 ? q2 : '0;
      saturated   <= (rf.use1 && s1) || (rf.use2 && s2);
    end
  end

endmodule

[rtl/qrs_div.sv]
// Pipelined rounded fixed-point divider, one quotient bit per stage, saturating.
// Depends on qrs_pkg.
module qrs_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [qrs_pkg::NUM_W-1:0]     num_mag,
  input  logic [qrs_pkg::DEN_W-1:0]     den_mag,
  input  logic                          neg,
  output logic [qrs_pkg::COEF_W-1:0]    quo,
  output logic                          sat
);

  localparam int QW = qrs_pkg::COEF_W;
  localparam int NW = qrs_pkg::NUM_W + qrs_pkg::FRAC_W + 2;
  localparam int DW = qrs_pkg::DEN_W + 1;

  logic [NW-1:0] n_a;
  logic [DW-1:0] d_a;
  logic          neg_a;

  logic [DW-1:0] rem [0:QW];
  logic [QW-1:0] low [0:QW];
  logic [QW-1:0] q   [0:QW];
  logic [DW-1:0] dd  [0:QW];
  logic          ng  [0:QW];
  logic          ov  [0:QW];

  logic [DW-1:0] rem_next [1:QW];
  logic          ge_next  [1:QW];

  always_comb begin
    for (int k = 1; k <= QW; k++) begin
      logic [DW:0] r2;
      r2 = {rem[k-1], low[k-1][QW-1]};
      ge_next[k]  = r2 >= {1'b0, dd[k-1]};
      rem_next[k] = ge_next[k] ? DW'(r2 - {1'b0, dd[k-1]}) : r2[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_a   <= {1'b0, num_mag, {(qrs_pkg::FRAC_W + 1){1'b0}}} + NW'(den_mag);
      d_a   <= {den_mag, 1'b0};
      neg_a <= neg;

      rem[0] <= DW'(n_a[NW-1:QW]);
      ov[0]  <= DW'(n_a[NW-1:QW]) >= d_a;
      low[0] <= n_a[QW-1:0];
      q[0]   <= '0;
      dd[0]  <= d_a;
      ng[0]  <= neg_a;

      for (int k = 1; k <= QW; k++) begin
        rem[k] <= rem_next[k];
        low[k] <= low[k-1] << 1;
        q[k]   <= {q[k-1][QW-2:0], ge_next[k]};
        dd[k]  <= dd[k-1];
        ng[k]  <= ng[k-1];
        ov[k]  <= ov[k-1];
      end
    end
  end

  logic [QW-1:0] limit;
  logic          over;
  logic [QW-1:0] mag;

  always_comb begin
    limit = (QW'(1) << (QW - 1)) - QW'(!ng[QW]);
    over  = ov[QW] || (q[QW] > limit);
    mag   = over ? limit : q[QW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo <= ng[QW] ? QW'(-mag) : mag;
      sat <= over;
    end
  end

endmodule

[tb/quadratic_root_solver_unit_tb.sv]
// Testbench for quadratic_root_solver_unit: directed and random coefficient sets,
// checked against a scoreboard that solves each set in bit-exact fixed point.
// Depends on qrs_pkg and the solver RTL.
`timescale 1ns / 100ps

module quadratic_root_solver_unit_tb;

  typedef struct {
    logic [1:0]  count;
    logic [31:0] r1;
    logic [31:0] r2;
    logic        sat;
  } roots_t;

  class root_scoreboard;
    roots_t pending[$];
    logic [30:0] tol;
    int mismatches;

    function new();
      tol = 31'd1;
      mismatches = 0;
    endfunction

    function automatic longint unsigned isqrt(logic [127:0] d);
      longint unsigned res, cand;
      logic [127:0] sq;
      res = 0;
      for (int i = 62; i >= 0; i--) begin
        cand = res | (64'd1 << i);
        sq = {64'd0, cand} * {64'd0, cand};
        if (d >= sq) res = cand;
      end
      return res;
    endfunction

    function automatic logic [31:0] div_round(longint num, longint den, inout logic sat);
      logic neg;
      logic [127:0] nm, dm, q, lim;
      neg = (num < 0) != (den < 0);
      nm = 128'(num < 0 ? -num : num);
      dm = 128'(den < 0 ? -den : den);
      q = ((nm << (qrs_pkg::FRAC_W + 1)) + dm) / (dm << 1);
      lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
      if (q > lim) begin
        sat = 1'b1;
        q = lim;
      end
      return neg ? -q[31:0] : q[31:0];
    endfunction

    function void note_coefs(logic [31:0] a, logic [31:0] b, logic [31:0] c);
      roots_t e;
      longint av, bv, cv, am, bm, cm, t, s;
      logic [127:0] b2, ac4, d;
      logic dneg;
      av = longint'($signed(a));
      bv = longint'($signed(b));
      cv = longint'($signed(c));
      am = av < 0 ? -av : av;
      bm = bv < 0 ? -bv : bv;
      cm = cv < 0 ? -cv : cv;
      t = (tol == 0) ? 1 : longint'(tol);
      e.count = qrs_pkg::CNT_NONE;
      e.r1 = '0;
      e.r2 = '0;
      e.sat = 1'b0;
      if (am < t) begin
        if (bm < t && cm < t) e.count = qrs_pkg::CNT_INF;
        else if (bm < t) e.count = qrs_pkg::CNT_NONE;
        else if (cm < t) e.count = qrs_pkg::CNT_ONE;
        else begin
          e.count = qrs_pkg::CNT_ONE;
          e.r1 = div_round(-cv, bv, e.sat);
        end
      end else begin
        b2 = 128'(bm) * 128'(bm);
        ac4 = (128'(am) * 128'(cm)) << 2;
        dneg = 1'b0;
        if ((av < 0) != (cv < 0) && cm != 0) d = b2 + ac4;
        else if (b2 >= ac4) d = b2 - ac4;
        else begin
          dneg = 1'b1;
          d = b2;
        end
        if (dneg) e.count = qrs_pkg::CNT_NONE;
        else if (d < (128'(t) << qrs_pkg::FRAC_W)) begin
          e.count = qrs_pkg::CNT_ONE;
          e.r1 = div_round(-bv, 2 * av, e.sat);
          e.r2 = e.r1;
        end else begin
          s = longint'(isqrt(d));
          e.count = qrs_pkg::CNT_TWO;
          e.r1 = div_round(-bv - s, 2 * av, e.sat);
          e.r2 = div_round(-bv + s, 2 * av, e.sat);
        end
      end
      pending.push_back(e);
    endfunction

    function void check_roots(logic [1:0] cnt, logic [31:0] r1, logic [31:0] r2, logic sat);
      roots_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: count %0d", cnt);
        return;
      end
      e = pending.pop_front();
      if (cnt !== e.count || r1 !== e.r1 || r2 !== e.r2 || sat !== e.sat) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp cnt %0d r1 %h r2 %h sat %b, got cnt %0d r1 %h r2 %h sat %b",
                   e.count, e.r1, e.r2, e.sat, cnt, r1, r2, sat);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [qrs_pkg::TOL_W-1:0] cfg_data = '0;
  logic coef_valid = 1'b0;
  logic coef_stall;
  logic signed [qrs_pkg::COEF_W-1:0] coef_quadratic = '0, coef_linear = '0,
                                     coef_constant = '0;
  logic root_valid;
  logic root_stall = 1'b0;
  logic [1:0] root_count;
  logic signed [qrs_pkg::COEF_W-1:0] first_root, second_root;
  logic saturated;

  int send_idle_pct = 9;
  int recv_stall_pct = 64;
  int quiet_cycles = 0;
  root_scoreboard sb = new();

  quadratic_root_solver_unit DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    root_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    if (!rst && coef_valid && !coef_stall)
      sb.note_coefs(coef_quadratic, coef_linear, coef_constant);
    if (!rst && root_valid && !root_stall)
      sb.check_roots(root_count, first_root, second_root, saturated);
    if ((coef_valid && !coef_stall) || (root_valid && !root_stall) || rst ||
        (!coef_valid && sb.pending.size() == 0))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_coefs(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      coef_valid <= 1'b0;
      @(posedge clk);
    end
    coef_valid <= 1'b1;
    coef_quadratic <= a;
    coef_linear <= b;
    coef_constant <= c;
    do @(posedge clk); while (coef_stall);
  endtask

  task automatic drain();
    coef_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [30:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.tol = v;
  endtask

  task automatic send_random(int n);
    int r1, r2, k;
    logic [31:0] a, b, c;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          a = $urandom; b = $urandom; c = $urandom;
        end
        3, 4, 5, 6: begin
          r1 = $urandom_range(0, 400) - 200;
          r2 = $urandom_range(0, 9) == 0 ? r1 : $urandom_range(0, 400) - 200;
          k = $urandom_range(1, 50) * ($urandom_range(0, 1) ? 1 : -1);
          a = k <<< qrs_pkg::FRAC_W;
          b = (-k * (r1 + r2)) <<< qrs_pkg::FRAC_W;
          c = (k * r1 * r2) <<< qrs_pkg::FRAC_W;
        end
        7: begin
          a = $urandom_range(0, 6) - 3; b = $urandom; c = $urandom;
        end
        8: begin
          a = $urandom_range(0, 2097152) - 1048576;
          b = $urandom_range(0, 2097152) - 1048576;
          c = $urandom_range(0, 2097152) - 1048576;
        end
        default: begin
          a = $urandom_range(0, 1) ? 32'd0 : $urandom;
          b = $urandom_range(0, 1) ? 32'd0 : $urandom;
          c = $urandom_range(0, 1) ? 32'd0 : $urandom;
        end
      endcase
      send_coefs(a, b, c);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_coefs(32'd0, 32'd0, 32'd0);
    send_coefs(32'd0, 32'd0, 32'h0005_0000);
    send_coefs(32'd0, 32'h0003_0000, 32'd0);
    send_coefs(32'd0, 32'h0002_0000, 32'hfffa_0000);
    send_coefs(32'd0, 32'd1, 32'h7fff_ffff);
    send_coefs(32'd0, 32'h8000_0000, 32'h8000_0000);
    send_coefs(32'h0001_0000, 32'h0002_0000, 32'h0005_0000);
    send_coefs(32'h0001_0000, 32'hfffe_0000, 32'h0001_0000);
    send_coefs(32'h0001_0000, 32'hfffe_0000, 32'h0000_ffff);
    send_coefs(32'h0001_0000, 32'd0, 32'hfffc_0000);
    send_coefs(32'h0002_0000, 32'h0006_0000, 32'h0004_0000);
    send_coefs(32'd1, 32'h7fff_ffff, 32'd0);
    send_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_coefs(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    send_coefs(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_coefs(32'hffff_ffff, 32'd0, 32'd1);
    write_tolerance(31'd0);
    send_coefs(32'd0, 32'd0, 32'd0);
    send_coefs(32'd1, 32'd2, 32'd1);
    send_coefs(32'd0, 32'd1, 32'd1);
    write_tolerance(31'h7fff_ffff);
    send_coefs(32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678);
    send_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_coefs(32'h8000_0000, 32'h4000_0000, 32'h7fff_ffff);
    write_tolerance(31'd1);

    send_random(300);
    write_tolerance(31'($urandom_range(0, 32'h7fff_ffff)));
    send_random(50);
    write_tolerance(31'd1000);
    send_idle_pct = 64;
    recv_stall_pct = 9;
    send_random(150);
    drain();
    send_random(150);
    write_tolerance(31'd0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_random(200);
    write_tolerance(31'd1);
    send_random(150);

    drain();
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule

[filelist.f]
rtl/qrs_pkg.sv
rtl/qrs_div.sv
rtl/quadratic_root_solver_unit.sv
tb/quadratic_root_solver_unit_tb.sv
